### design/piecewise_linear_interp_table_core_macros.svh
// Assertion helpers for the interpolation table core
`ifndef PIECEWISE_LINEAR_INTERP_TABLE_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_INTERP_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define PLI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int KEY_BITS_DEF    = 16;
	localparam int VALUE_BITS_DEF  = 16;

	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       append;
		logic       scan_start;
		logic       scan_active;
		logic       scan_adv;
		logic       div_start;
		logic       div_step;
		logic       res_zero;
		logic       res_load_rd;
		logic       res_load_div;
		logic       out_load;
		logic [1:0] status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic x_gt;
		logic idx_last;
		logic idx_zero;
		logic div_last;
	} sts_t;

endpackage

### design/pli_dp.sv
`timescale 1ns / 1ps

module pli_dp #(
	parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = pli_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS  = pli_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  pli_pkg::cmd_t         cmd,
	output pli_pkg::sts_t         sts,
	output logic [VALUE_BITS-1:0] result_value,
	output logic [1:0]            status
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int BIT_W = $clog2(VALUE_BITS);

	logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] value_mem [TABLE_DEPTH];

	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      rd_addr;
	logic [KEY_BITS-1:0]   rd_key_q, x_q, k_lo_q;
	logic [VALUE_BITS-1:0] rd_val_q, v_lo_q, base_q;
	logic [VALUE_BITS-1:0] a_q, q_q, res_q, result_value_q;
	logic [KEY_BITS-1:0]   b_q, d_q, r_q;
	logic                  neg_q;
	logic [BIT_W-1:0]      bit_q;
	logic [1:0]            status_q;

	logic [VALUE_BITS:0]   dv;
	logic [KEY_BITS:0]     dx, dk;
	logic [VALUE_BITS:0]   dv_mag;
	logic [KEY_BITS:0]     dx_mag, dk_mag;
	logic [KEY_BITS+1:0]   t, d1, d2;
	logic [VALUE_BITS-1:0] q_sh;

	assign rd_addr = cmd.scan_active ? IDX_W'(idx_q + IDX_W'(1)) : '0;

	// table storage, registered read port
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			key_mem[cnt_q[IDX_W-1:0]]   <= key;
			value_mem[cnt_q[IDX_W-1:0]] <= value;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= value_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.append) begin
			cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
		end
	end

	always_comb begin
		dv     = {v_lo_q[VALUE_BITS-1], v_lo_q} - {rd_val_q[VALUE_BITS-1], rd_val_q};
		dx     = {x_q[KEY_BITS-1], x_q} - {rd_key_q[KEY_BITS-1], rd_key_q};
		dk     = {k_lo_q[KEY_BITS-1], k_lo_q} - {rd_key_q[KEY_BITS-1], rd_key_q};
		dv_mag = dv[VALUE_BITS] ? -dv : dv;
		dx_mag = dx[KEY_BITS] ? -dx : dx;
		dk_mag = dk[KEY_BITS] ? -dk : dk;
		// r < d, so 2r + b < 3d: at most two subtractions of d per step
		t      = {1'b0, r_q, 1'b0} + {2'b00, (a_q[VALUE_BITS-1] ? b_q : '0)};
		d1     = {2'b00, d_q};
		d2     = {1'b0, d_q, 1'b0};
		q_sh   = {q_q[VALUE_BITS-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			x_q   <= key;
			idx_q <= '0;
		end
		if (cmd.scan_adv) begin
			k_lo_q <= rd_key_q;
			v_lo_q <= rd_val_q;
			idx_q  <= IDX_W'(idx_q + IDX_W'(1));
		end
		if (cmd.div_start) begin
			a_q    <= dv_mag[VALUE_BITS-1:0];
			b_q    <= dx_mag[KEY_BITS-1:0];
			d_q    <= dk_mag[KEY_BITS-1:0];
			r_q    <= '0;
			q_q    <= '0;
			bit_q  <= '0;
			neg_q  <= dv[VALUE_BITS] ^ dx[KEY_BITS] ^ dk[KEY_BITS];
			base_q <= rd_val_q;
		end
		if (cmd.div_step) begin
			if (t >= d2) begin
				r_q <= KEY_BITS'(t - d2);
				q_q <= VALUE_BITS'(q_sh + VALUE_BITS'(2));
			end else if (t >= d1) begin
				r_q <= KEY_BITS'(t - d1);
				q_q <= VALUE_BITS'(q_sh + VALUE_BITS'(1));
			end else begin
				r_q <= KEY_BITS'(t);
				q_q <= q_sh;
			end
			a_q   <= {a_q[VALUE_BITS-2:0], 1'b0};
			bit_q <= BIT_W'(bit_q + BIT_W'(1));
		end
		if (cmd.res_zero) begin
			res_q <= '0;
		end
		if (cmd.res_load_rd) begin
			res_q <= rd_val_q;
		end
		if (cmd.res_load_div) begin
			res_q <= neg_q ? VALUE_BITS'(base_q - q_q) : VALUE_BITS'(base_q + q_q);
		end
		if (cmd.out_load) begin
			result_value_q <= res_q;
			status_q       <= cmd.status;
		end
	end

	always_comb begin
		sts.full     = (cnt_q == CNT_W'(TABLE_DEPTH));
		sts.empty    = (cnt_q == '0);
		sts.x_gt     = ($signed(x_q) > $signed(rd_key_q));
		sts.idx_last = (CNT_W'(CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
		sts.idx_zero = (idx_q == '0);
		sts.div_last = (bit_q == BIT_W'(VALUE_BITS - 1));
	end

	assign result_value = result_value_q;
	assign status       = status_q;

endmodule

### design/pli_ctrl.sv
`timescale 1ns / 1ps

module pli_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            action,
	input  logic            out_stall,
	input  pli_pkg::sts_t   sts,
	output pli_pkg::cmd_t   cmd,
	output logic            in_stall,
	output logic            out_valid,
	output pli_pkg::state_t state
);

	pli_pkg::state_t state_q, state_d;
	logic [1:0]      st_q, st_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pli_pkg::S_IDLE;
			st_q        <= pli_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		st_d            = st_q;
		cmd             = '0;
		cmd.status      = st_q;
		cmd.scan_active = (state_q == pli_pkg::S_SCAN);
		case (state_q)
			pli_pkg::S_IDLE: begin
				if (in_valid) begin
					if (action == pli_pkg::ACT_APPEND) begin
						cmd.append   = !sts.full;
						cmd.res_zero = 1'b1;
						st_d         = sts.full ? pli_pkg::ST_FULL : pli_pkg::ST_OK;
						state_d      = pli_pkg::S_DONE;
					end else if (sts.empty) begin
						cmd.res_zero = 1'b1;
						st_d         = pli_pkg::ST_EMPTY;
						state_d      = pli_pkg::S_DONE;
					end else begin
						cmd.scan_start = 1'b1;
						st_d           = pli_pkg::ST_OK;
						state_d        = pli_pkg::S_SCAN;
					end
				end
			end
			pli_pkg::S_SCAN: begin
				if (sts.x_gt) begin
					if (sts.idx_last) begin
						cmd.res_load_rd = 1'b1;
						state_d         = pli_pkg::S_DONE;
					end else begin
						cmd.scan_adv = 1'b1;
					end
				end else if (sts.idx_zero) begin
					cmd.res_load_rd = 1'b1;
					state_d         = pli_pkg::S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = pli_pkg::S_DIV;
				end
			end
			pli_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = pli_pkg::S_FIN;
				end
			end
			pli_pkg::S_FIN: begin
				cmd.res_load_div = 1'b1;
				state_d          = pli_pkg::S_DONE;
			end
			pli_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = pli_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pli_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != pli_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

### design/piecewise_linear_interp_table_core.sv
// Piecewise linear interpolation table.
// Input channel (in_valid/in_stall): action, key, value. An append stores one
// (key, value) breakpoint unless the table is full; a query returns the value
// interpolated at key. Output channel (out_valid/out_stall): result_value,
// status; one transaction out for every transaction in, in order.
// Sequencing: an append or a query on an empty table goes straight to the
// finish state. A query scans one stored key per cycle through the key memory
// read port, then runs a one-bit-per-cycle multiply-divide; an end-point query
// takes its result from the scan and skips the divide.
// The result appears on out_valid the cycle after the block finishes.
// A finished result waits in the output register while out_stall is high; the
// next input transaction is still taken, and its result is held until the
// output register frees up.
// Reset clears the entry count and the handshake state; stored breakpoints are
// not cleared, and entries beyond the entry count are never used.
`timescale 1ns / 1ps
`include "piecewise_linear_interp_table_core_macros.svh"

module piecewise_linear_interp_table_core #(
	parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = pli_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS  = pli_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_BITS-1:0] result_value,
	output logic [1:0]            status
);

	pli_pkg::cmd_t   cmd;
	pli_pkg::sts_t   sts;
	pli_pkg::state_t state;

	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.state     (state)
	);

	pli_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.key          (key),
		.value        (value),
		.cmd          (cmd),
		.sts          (sts),
		.result_value (result_value),
		.status       (status)
	);

	`PLI_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
	`PLI_ASSERT_IMP(a_zero_on_flag, out_valid && (status == pli_pkg::ST_FULL || status == pli_pkg::ST_EMPTY), result_value == '0, "nonzero result with flag")
	`PLI_ASSERT_IMP(a_load_from_done, $rose(out_valid), $past(state == pli_pkg::S_DONE), "result shown without finish")

endmodule

### tb/sv/tb_piecewise_linear_interp_table_core.sv
`timescale 1ns / 1ps

module tb_piecewise_linear_interp_table_core;

	localparam int RUN_LIMIT    = 400000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 300;
	localparam int DRAIN_CYCLES = 60;

	class interp_tracker;
		logic signed [15:0] keys [pli_pkg::TABLE_DEPTH_DEF];
		logic signed [15:0] vals [pli_pkg::TABLE_DEPTH_DEF];
		int count;
		logic [15:0] pending_values [$];
		logic [1:0]  pending_status [$];
		int answered, errors;
		int n_append, n_full, n_query, n_empty, n_interp;

		function void record_request(logic act, logic signed [15:0] x,
				logic signed [15:0] v);
			int i;
			longint dv, dx, dk;
			logic signed [15:0] y;
			logic [1:0] st;
			y = '0;
			st = pli_pkg::ST_OK;
			if (act == pli_pkg::ACT_APPEND) begin
				n_append++;
				if (count >= pli_pkg::TABLE_DEPTH_DEF) begin
					st = pli_pkg::ST_FULL;
					n_full++;
				end else begin
					keys[count] = x;
					vals[count] = v;
					count++;
				end
			end else begin
				n_query++;
				if (count == 0) begin
					st = pli_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					i = 0;
					while (i < count && x > keys[i])
						i++;
					if (i == 0) begin
						y = vals[0];
					end else if (i >= count) begin
						y = vals[count-1];
					end else begin
						// exact product, quotient truncated toward zero
						dv = longint'(vals[i-1]) - longint'(vals[i]);
						dx = longint'(x) - longint'(keys[i]);
						dk = longint'(keys[i-1]) - longint'(keys[i]);
						y = 16'(longint'(vals[i]) + (dv * dx) / dk);
						n_interp++;
					end
				end
			end
			pending_values = {pending_values, y};
			pending_status = {pending_status, st};
		endfunction

		function void compare_answer(logic [15:0] rv, logic [1:0] st);
			logic [15:0] ev;
			logic [1:0] es;
			answered++;
			if (pending_values.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected result value=%0d status=%0d",
						$signed(rv), st);
				return;
			end
			ev = pending_values.pop_front();
			es = pending_status.pop_front();
			if (rv !== ev || st !== es) begin
				errors++;
				if (errors <= 10) begin
					$write("ERROR: result %0d: expected value=%0d status=%0d",
						answered, $signed(ev), es);
					$display(", got value=%0d status=%0d", $signed(rv), st);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = pli_pkg::ACT_APPEND;
	logic [15:0] key = '0;
	logic [15:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] result_value;
	logic [1:0] status;

	interp_tracker sb = new();
	int cycles = 0;
	int burst_left = 0;

	piecewise_linear_interp_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.status(status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("tb_piecewise_linear_interp_table_core: FAIL");
			$finish;
		end
	end

	task automatic offer(input logic act, input logic [15:0] k, input logic [15:0] v);
		int gap;
		in_valid <= 1'b1;
		action <= act;
		key <= k;
		value <= v;
		do @(posedge clk); while (in_stall);
		sb.record_request(act, k, v);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 11);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// receiver: stall modes of random length, plus one long hold-off
	initial begin
		int mode, mode_left, hold_left;
		bit held;
		logic nxt;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.compare_answer(result_value, status);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b1;
			end else if (!held && sb.answered >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				nxt = 1'b1;
			end else if (mode == 0) begin
				nxt = 1'b0;
			end else if (mode == 1) begin
				nxt = ($urandom_range(0, 3) == 0);
			end else begin
				nxt = ($urandom_range(0, 3) != 0);
			end
			out_stall <= nxt;
		end
	end

	initial begin
		int n, r, j, t, top;
		logic [15:0] k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then a small table with a repeated and an out-of-order key
		offer(pli_pkg::ACT_QUERY, 16'sd0, 16'h7fff);
		offer(pli_pkg::ACT_QUERY, 16'h8000, 16'h8000);
		offer(pli_pkg::ACT_APPEND, -16'sd20000, 16'h8000);
		offer(pli_pkg::ACT_QUERY, 16'h8000, 16'h0000);
		offer(pli_pkg::ACT_QUERY, 16'h7fff, 16'hffff);
		offer(pli_pkg::ACT_QUERY, -16'sd20000, 16'h0000);
		offer(pli_pkg::ACT_APPEND, -16'sd10000, 16'h7fff);
		offer(pli_pkg::ACT_QUERY, -16'sd15000, 16'h0000);
		offer(pli_pkg::ACT_QUERY, -16'sd19999, 16'h0000);
		offer(pli_pkg::ACT_QUERY, -16'sd10000, 16'h0000);
		offer(pli_pkg::ACT_APPEND, -16'sd10000, 16'h0000);
		offer(pli_pkg::ACT_QUERY, -16'sd10001, 16'h0000);
		offer(pli_pkg::ACT_QUERY, -16'sd9999, 16'h0000);
		offer(pli_pkg::ACT_APPEND, 16'sd5000, 16'h4000);
		offer(pli_pkg::ACT_APPEND, 16'sd0, 16'hc000);
		offer(pli_pkg::ACT_QUERY, 16'sd2000, 16'h0000);
		offer(pli_pkg::ACT_QUERY, 16'sd6000, 16'h5555);

		top = 5000;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if ((sb.count < pli_pkg::TABLE_DEPTH_DEF && r < 15) || r < 5) begin
				if (sb.count == pli_pkg::TABLE_DEPTH_DEF - 1) begin
					t = 32767;
				end else if ($urandom_range(0, 9) == 0) begin
					t = $signed(16'($urandom));
				end else begin
					t = top + int'($urandom_range(1, 4000));
					if (t > 32766)
						t = 32766;
				end
				if (t > top)
					top = t;
				k = t[15:0];
				offer(pli_pkg::ACT_APPEND, k, 16'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				j = $urandom_range(0, (sb.count > 0) ? sb.count - 1 : 0);
				if (r < 50) begin
					t = int'(sb.keys[j]) - int'($urandom_range(0, 8000));
				end else if (r < 75) begin
					t = int'(sb.keys[j]) + int'($urandom_range(0, 2)) - 1;
				end else begin
					t = $signed(16'($urandom));
				end
				if (t < -32768)
					t = -32768;
				if (t > 32767)
					t = 32767;
				k = t[15:0];
				offer(pli_pkg::ACT_QUERY, k, 16'($urandom));
			end
		end
		in_valid <= 1'b0;

		while (sb.pending_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d appends (%0d dropped on a full table) and %0d queries",
			sb.n_append, sb.n_full, sb.n_query);
		$display("  (%0d on an empty table, %0d interpolated), %0d results checked",
			sb.n_empty, sb.n_interp, sb.answered);
		if (sb.errors == 0 && sb.pending_values.size() == 0) begin
			$display("tb_piecewise_linear_interp_table_core: PASS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("tb_piecewise_linear_interp_table_core: FAIL");
		end
		$finish;
	end

endmodule
